FILE: rtl/cell_list_binning_core_assert.svh
// ----------------------------------------------------------------------------
// Cell list binning assertion macros
// Shared property forms for the checker of the cell list binning core.
// ----------------------------------------------------------------------------
`ifndef CELL_LIST_BINNING_CORE_ASSERT_SVH
`define CELL_LIST_BINNING_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLB_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/cellb_pkg.sv
// ----------------------------------------------------------------------------
// Cell list binning package
// Widths, codes, state encoding and unit request types shared by the core.
// ----------------------------------------------------------------------------
package cellb_pkg;

	// Field widths.
	localparam int POS_W     = 32;
	localparam int INV_W     = 32;
	localparam int FRAC_W    = 48;
	localparam int SIDE_W    = 5;
	localparam int COORD_W   = 4;
	localparam int PID_W     = 12;
	localparam int CELL_W    = 12;
	localparam int LINK_W    = 13;
	localparam int COUNT_W   = 13;
	localparam int TMP_W     = 9;
	localparam int CFG_IDX_W = 3;

	// Store sizes and special values.
	localparam int MAX_CELLS = 4096;
	localparam int MAX_SIDE  = 16;
	localparam int MIN_SIDE  = 3;
	localparam logic [LINK_W-1:0]  LINK_EMPTY  = LINK_W'(4096);
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(4097);
	localparam logic [CELL_W-1:0]  CELL_LAST   = CELL_W'(MAX_CELLS - 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_N_SIDE_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_N_SIDE_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_N_SIDE_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_BOX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_BOX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_BOX_Z = 3'd5;

	// Operation codes carried on the input side-band.
	typedef enum logic [1:0] {
		OP_LOCATE = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_COUNT  = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_AXIS,
		ST_INDEX,
		ST_HEAD,
		ST_WALK_RD,
		ST_WALK_HD,
		ST_WALK_LK,
		ST_DONE
	} state_t;

	// Request to the shared axis unit.
	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [INV_W-1:0]  inv;
		logic [SIDE_W-1:0] side;
	} axis_req_t;

	// Request to the linear index unit: (a * side_y + b) * side_z + c.
	typedef struct packed {
		logic [SIDE_W-1:0]  a;
		logic [COORD_W-1:0] b;
		logic [COORD_W-1:0] c;
		logic [SIDE_W-1:0]  side_y;
		logic [SIDE_W-1:0]  side_z;
	} idx_req_t;

endpackage

FILE: rtl/cell_list_binning_core.sv
// ----------------------------------------------------------------------------
// Cell list binning core
// Periodic 3-D linked cell list: locate, insert, clear and count check.
// ----------------------------------------------------------------------------
// Items enter on the s_ channel (op on s_tuser) and each gives one result on
// the m_ channel. Side counts and reciprocal box lengths are written on the
// cfg_ channel, which is always ready; the user must write them only while
// the core is idle, as the core itself does not enforce it.
// One item is worked on at a time; s_tready is low until its result has been
// placed in the output register. Locate and insert pass the three axes
// through one shared axis unit, then the index arithmetic; insert adds one
// head read-modify-write. Clear writes one list head per cycle. Count
// reads the head of each active cell and then follows its links (head and
// link memories each give one registered read per cycle).
// After reset the core sweeps all 4096 list heads to empty with s_tready
// low; configuration writes are taken meanwhile.
// A stalled receiver holds the result in the output register; the core can
// accept the next item meanwhile and waits at its end until the register
// is free.
// ----------------------------------------------------------------------------
module cell_list_binning_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input items.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// particle_id[11:0], pos_x[43:12], pos_y[75:44], pos_z[107:76],
	// expected_count[120:108], zero fill [127:121]
	input  logic [127:0]                    s_tdata,
	// op[1:0]
	input  logic [1:0]                      s_tuser,
	// Results.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cell_lin[11:0], cell_x[15:12], cell_y[19:16], cell_z[23:20],
	// old_head[36:24], particle_count[49:37], mismatch[50], zero fill [55:51]
	output logic [55:0]                     m_tdata,
	// Configuration writes.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cellb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data
);

	// Side count clamped to the supported range.
	function automatic logic [cellb_pkg::SIDE_W-1:0] eff_side(
		input logic [cellb_pkg::SIDE_W-1:0] n
	);
		logic [cellb_pkg::SIDE_W-1:0] r;
		r = n;
		if (n < cellb_pkg::SIDE_W'(cellb_pkg::MIN_SIDE)) begin
			r = cellb_pkg::SIDE_W'(cellb_pkg::MIN_SIDE);
		end else if (n > cellb_pkg::SIDE_W'(cellb_pkg::MAX_SIDE)) begin
			r = cellb_pkg::SIDE_W'(cellb_pkg::MAX_SIDE);
		end
		return r;
	endfunction

	// Configuration registers.
	logic [cellb_pkg::SIDE_W-1:0] n_side_x_q, n_side_y_q, n_side_z_q;
	logic [cellb_pkg::INV_W-1:0]  inv_box_x_q, inv_box_y_q, inv_box_z_q;
	logic [cellb_pkg::SIDE_W-1:0] nx, ny, nz;

	// Sequencer.
	cellb_pkg::state_t         state_q, state_d;
	logic [2:0]                step_q, step_d;
	logic [cellb_pkg::CELL_W-1:0] clr_addr_q, clr_addr_d;
	logic                      clr_reply_q, clr_reply_d;
	logic                      out_valid_q, out_valid_d;
	logic                      out_load;
	logic                      walk_inc;
	logic                      walk_next_cell;

	// Item and working registers.
	cellb_pkg::op_t               op_q;
	logic [cellb_pkg::PID_W-1:0]  pid_q;
	logic [cellb_pkg::POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
	logic [cellb_pkg::COUNT_W-1:0] expected_q;
	logic [cellb_pkg::COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [cellb_pkg::CELL_W-1:0] cell_q;
	logic [cellb_pkg::LINK_W-1:0] old_q;
	logic [cellb_pkg::COUNT_W-1:0] ncells_q;
	logic [cellb_pkg::COUNT_W-1:0] c_q;
	logic [cellb_pkg::COUNT_W-1:0] c_next;
	logic [cellb_pkg::COUNT_W-1:0] count_q;
	logic [55:0]                  out_data_q;
	logic [55:0]                  out_data;

	// Shared units.
	cellb_pkg::axis_req_t          axis_req;
	logic [cellb_pkg::COORD_W-1:0] axis_coord;
	cellb_pkg::idx_req_t           idx_req;
	logic [cellb_pkg::COUNT_W-1:0] idx_res;

	// Memories.
	logic [cellb_pkg::LINK_W-1:0] heads_mem [cellb_pkg::MAX_CELLS];
	logic [cellb_pkg::LINK_W-1:0] links_mem [cellb_pkg::MAX_CELLS];
	logic                         head_we, link_we;
	logic [cellb_pkg::CELL_W-1:0] head_waddr, head_raddr;
	logic [cellb_pkg::PID_W-1:0]  link_waddr, link_raddr;
	logic [cellb_pkg::LINK_W-1:0] head_wdata, link_wdata;
	logic [cellb_pkg::LINK_W-1:0] head_rdata_q, link_rdata_q;
	logic [cellb_pkg::LINK_W-1:0] walk_p;

	assign nx = eff_side(n_side_x_q);
	assign ny = eff_side(n_side_y_q);
	assign nz = eff_side(n_side_z_q);

	// Configuration write port.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_side_x_q  <= cellb_pkg::SIDE_W'(3);
			n_side_y_q  <= cellb_pkg::SIDE_W'(3);
			n_side_z_q  <= cellb_pkg::SIDE_W'(3);
			inv_box_x_q <= 32'd268435456;
			inv_box_y_q <= 32'd268435456;
			inv_box_z_q <= 32'd268435456;
		end else if (cfg_valid) begin
			case (cfg_index)
				cellb_pkg::CFG_N_SIDE_X:  n_side_x_q  <= cfg_data[cellb_pkg::SIDE_W-1:0];
				cellb_pkg::CFG_N_SIDE_Y:  n_side_y_q  <= cfg_data[cellb_pkg::SIDE_W-1:0];
				cellb_pkg::CFG_N_SIDE_Z:  n_side_z_q  <= cfg_data[cellb_pkg::SIDE_W-1:0];
				cellb_pkg::CFG_INV_BOX_X: inv_box_x_q <= cfg_data;
				cellb_pkg::CFG_INV_BOX_Y: inv_box_y_q <= cfg_data;
				cellb_pkg::CFG_INV_BOX_Z: inv_box_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Axis unit: one axis enters per cycle; its coordinate comes out of the unit's stage registers.
	always_comb begin
		case (step_q)
			3'd0: begin
				axis_req.pos  = pos_x_q;
				axis_req.inv  = inv_box_x_q;
				axis_req.side = nx;
			end
			3'd1: begin
				axis_req.pos  = pos_y_q;
				axis_req.inv  = inv_box_y_q;
				axis_req.side = ny;
			end
			default: begin
				axis_req.pos  = pos_z_q;
				axis_req.inv  = inv_box_z_q;
				axis_req.side = nz;
			end
		endcase
	end

	cellb_axis u_axis (
		.clk   (clk),
		.req   (axis_req),
		.coord (axis_coord)
	);

	// Index unit: the count check feeds side counts to get the cell total.
	always_comb begin
		idx_req.side_y = ny;
		idx_req.side_z = nz;
		if (op_q == cellb_pkg::OP_COUNT) begin
			idx_req.a = nx;
			idx_req.b = '0;
			idx_req.c = '0;
		end else begin
			idx_req.a = {1'b0, cx_q};
			idx_req.b = cy_q;
			idx_req.c = cz_q;
		end
	end

	cellb_index u_index (
		.clk    (clk),
		.req    (idx_req),
		.result (idx_res)
	);

	// List head memory.
	always_ff @(posedge clk) begin
		if (head_we) begin
			heads_mem[head_waddr] <= head_wdata;
		end
		head_rdata_q <= heads_mem[head_raddr];
	end

	// Next link memory.
	always_ff @(posedge clk) begin
		if (link_we) begin
			links_mem[link_waddr] <= link_wdata;
		end
		link_rdata_q <= links_mem[link_raddr];
	end

	// The walk looks at a head right after its read, and at links after that.
	assign walk_p = (state_q == cellb_pkg::ST_WALK_HD) ? head_rdata_q : link_rdata_q;
	assign c_next = c_q + cellb_pkg::COUNT_W'(1);

	// Next state, memory controls and working register enables.
	always_comb begin
		state_d        = state_q;
		step_d         = step_q;
		clr_addr_d     = clr_addr_q;
		clr_reply_d    = clr_reply_q;
		out_load       = 1'b0;
		walk_inc       = 1'b0;
		walk_next_cell = 1'b0;
		head_we        = 1'b0;
		head_waddr     = clr_addr_q;
		head_wdata     = cellb_pkg::LINK_EMPTY;
		head_raddr     = c_q[cellb_pkg::CELL_W-1:0];
		link_we        = 1'b0;
		link_waddr     = pid_q;
		link_wdata     = head_rdata_q;
		link_raddr     = walk_p[cellb_pkg::PID_W-1:0];
		case (state_q)
			cellb_pkg::ST_CLEAR: begin
				head_we    = 1'b1;
				clr_addr_d = clr_addr_q + cellb_pkg::CELL_W'(1);
				if (clr_addr_q == cellb_pkg::CELL_LAST) begin
					clr_reply_d = 1'b0;
					state_d     = clr_reply_q ? cellb_pkg::ST_DONE : cellb_pkg::ST_IDLE;
				end
			end
			cellb_pkg::ST_IDLE: begin
				step_d = '0;
				if (s_tvalid) begin
					case (cellb_pkg::op_t'(s_tuser))
						cellb_pkg::OP_CLEAR: begin
							clr_addr_d  = '0;
							clr_reply_d = 1'b1;
							state_d     = cellb_pkg::ST_CLEAR;
						end
						cellb_pkg::OP_COUNT: state_d = cellb_pkg::ST_INDEX;
						default:             state_d = cellb_pkg::ST_AXIS;
					endcase
				end
			end
			cellb_pkg::ST_AXIS: begin
				step_d = step_q + 3'd1;
				if (step_q == 3'd4) begin
					step_d  = '0;
					state_d = cellb_pkg::ST_INDEX;
				end
			end
			cellb_pkg::ST_INDEX: begin
				step_d = step_q + 3'd1;
				if (step_q == 3'd2) begin
					step_d     = '0;
					head_raddr = idx_res[cellb_pkg::CELL_W-1:0];
					case (op_q)
						cellb_pkg::OP_COUNT:  state_d = cellb_pkg::ST_WALK_RD;
						cellb_pkg::OP_INSERT: state_d = cellb_pkg::ST_HEAD;
						default:              state_d = cellb_pkg::ST_DONE;
					endcase
				end
			end
			cellb_pkg::ST_HEAD: begin
				// Push the particle in front of the old head.
				head_we    = 1'b1;
				head_waddr = cell_q;
				head_wdata = {1'b0, pid_q};
				link_we    = 1'b1;
				state_d    = cellb_pkg::ST_DONE;
			end
			cellb_pkg::ST_WALK_RD: begin
				state_d = cellb_pkg::ST_WALK_HD;
			end
			cellb_pkg::ST_WALK_HD, cellb_pkg::ST_WALK_LK: begin
				if (!walk_p[cellb_pkg::LINK_W-1] && count_q != cellb_pkg::COUNT_LIMIT) begin
					walk_inc = 1'b1;
					state_d  = cellb_pkg::ST_WALK_LK;
				end else if (c_next >= ncells_q || count_q == cellb_pkg::COUNT_LIMIT) begin
					state_d = cellb_pkg::ST_DONE;
				end else begin
					walk_next_cell = 1'b1;
					state_d        = cellb_pkg::ST_WALK_RD;
				end
			end
			cellb_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = cellb_pkg::ST_IDLE;
				end
			end
			default: state_d = cellb_pkg::ST_IDLE;
		endcase
	end

	// Output register valid.
	always_comb begin
		out_valid_d = out_valid_q;
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (m_tready) begin
			out_valid_d = 1'b0;
		end
	end

	// Control registers; reset starts the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cellb_pkg::ST_CLEAR;
			step_q      <= '0;
			clr_addr_q  <= '0;
			clr_reply_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			clr_addr_q  <= clr_addr_d;
			clr_reply_q <= clr_reply_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Result packing; fields an op does not produce are zero.
	always_comb begin
		out_data = '0;
		case (op_q)
			cellb_pkg::OP_LOCATE: begin
				out_data[23:0] = {cz_q, cy_q, cx_q, cell_q};
			end
			cellb_pkg::OP_INSERT: begin
				out_data[36:0] = {old_q, cz_q, cy_q, cx_q, cell_q};
			end
			cellb_pkg::OP_COUNT: begin
				out_data[49:37] = count_q;
				out_data[50]    = (count_q != expected_q);
			end
			default: out_data = '0;
		endcase
	end

	// Item and working registers.
	always_ff @(posedge clk) begin
		if (state_q == cellb_pkg::ST_IDLE && s_tvalid) begin
			op_q       <= cellb_pkg::op_t'(s_tuser);
			pid_q      <= s_tdata[11:0];
			pos_x_q    <= s_tdata[43:12];
			pos_y_q    <= s_tdata[75:44];
			pos_z_q    <= s_tdata[107:76];
			expected_q <= s_tdata[120:108];
		end
		if (state_q == cellb_pkg::ST_AXIS) begin
			case (step_q)
				3'd2:    cx_q <= axis_coord;
				3'd3:    cy_q <= axis_coord;
				3'd4:    cz_q <= axis_coord;
				default: ;
			endcase
		end
		if (state_q == cellb_pkg::ST_INDEX && step_q == 3'd2) begin
			cell_q   <= idx_res[cellb_pkg::CELL_W-1:0];
			ncells_q <= idx_res;
			c_q      <= '0;
			count_q  <= '0;
		end
		if (state_q == cellb_pkg::ST_HEAD) begin
			old_q <= head_rdata_q;
		end
		if (walk_inc) begin
			count_q <= count_q + cellb_pkg::COUNT_W'(1);
		end
		if (walk_next_cell) begin
			c_q <= c_next;
		end
		if (out_load) begin
			out_data_q <= out_data;
		end
	end

	assign s_tready = (state_q == cellb_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: rtl/cellb_axis.sv
// ----------------------------------------------------------------------------
// Cell list binning axis unit
// Two-stage shared unit: position times reciprocal box length, keep the
// periodic fraction, then scale the fraction by the side count.
// ----------------------------------------------------------------------------
module cellb_axis (
	input  logic                          clk,
	input  cellb_pkg::axis_req_t          req,
	output logic [cellb_pkg::COORD_W-1:0] coord
);

	logic signed [2*cellb_pkg::POS_W+1:0] prod;
	logic [cellb_pkg::FRAC_W-1:0]         frac_s1;
	logic [cellb_pkg::SIDE_W-1:0]         side_s1;
	logic [cellb_pkg::FRAC_W+cellb_pkg::SIDE_W-1:0] scaled;
	logic [cellb_pkg::COORD_W-1:0]        coord_s2;

	// Signed position times unsigned reciprocal; the low bits hold the wrap.
	assign prod = $signed({req.pos[cellb_pkg::POS_W-1], req.pos}) * $signed({1'b0, req.inv});

	always_ff @(posedge clk) begin
		frac_s1 <= prod[cellb_pkg::FRAC_W-1:0];
		side_s1 <= req.side;
	end

	// The integer part of fraction times side count is the coordinate.
	assign scaled = (cellb_pkg::FRAC_W + cellb_pkg::SIDE_W)'(frac_s1) *
		(cellb_pkg::FRAC_W + cellb_pkg::SIDE_W)'(side_s1);

	always_ff @(posedge clk) begin
		coord_s2 <= scaled[cellb_pkg::FRAC_W +: cellb_pkg::COORD_W];
	end

	assign coord = coord_s2;

endmodule

FILE: rtl/cellb_index.sv
// ----------------------------------------------------------------------------
// Cell list binning index unit
// Two-stage multiply-add that forms the linear cell index, and the number
// of active cells when the coordinates are replaced by the side counts.
// ----------------------------------------------------------------------------
module cellb_index (
	input  logic                          clk,
	input  cellb_pkg::idx_req_t           req,
	output logic [cellb_pkg::COUNT_W-1:0] result
);

	logic [2*cellb_pkg::SIDE_W-1:0]  row_full;
	logic [cellb_pkg::TMP_W-1:0]     row_s1;
	logic [cellb_pkg::COORD_W-1:0]   c_s1;
	logic [cellb_pkg::SIDE_W-1:0]    side_z_s1;
	logic [cellb_pkg::COUNT_W:0]     lin_full;
	logic [cellb_pkg::COUNT_W-1:0]   lin_s2;

	// First stage: a * side_y + b.
	assign row_full = (2*cellb_pkg::SIDE_W)'(req.a) * (2*cellb_pkg::SIDE_W)'(req.side_y) +
		(2*cellb_pkg::SIDE_W)'(req.b);

	always_ff @(posedge clk) begin
		row_s1    <= row_full[cellb_pkg::TMP_W-1:0];
		c_s1      <= req.c;
		side_z_s1 <= req.side_z;
	end

	// Second stage: row * side_z + c.
	assign lin_full = (cellb_pkg::COUNT_W+1)'(row_s1) * (cellb_pkg::COUNT_W+1)'(side_z_s1) +
		(cellb_pkg::COUNT_W+1)'(c_s1);

	always_ff @(posedge clk) begin
		lin_s2 <= lin_full[cellb_pkg::COUNT_W-1:0];
	end

	assign result = lin_s2;

endmodule

FILE: rtl/cellb_checker.sv
// ----------------------------------------------------------------------------
// Cell list binning port checker
// Watches the core's ports over time and flags broken results or handshakes.
// ----------------------------------------------------------------------------
`include "cell_list_binning_core_assert.svh"

module cellb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// A stalled result stays put.
	`CLB_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Only one item is worked on at a time.
	`CLB_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "second item taken while busy")

	// The walk count never passes its saturation value.
	`CLB_ASSERT_NOW(a_count_sat, clk, arst_n, m_tvalid, m_tdata[49:37] <= 13'd4097, "particle count beyond saturation")

	// A mismatch comes only from a count check, which carries no location.
	`CLB_ASSERT_NOW(a_mis_clean, clk, arst_n, m_tvalid && m_tdata[50], m_tdata[36:0] == 37'd0, "mismatch result carries location fields")

endmodule

bind cell_list_binning_core cellb_checker u_cellb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
